/* src/b64d_pkg.sv */
// shared types, character codes and the alphabet lookup for the base64 stream decoder
package b64d_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned SextW  = 6;
  localparam int unsigned ErrW   = 2;
  localparam int unsigned QDepth = 3;

  localparam logic [CharW-1:0] CHAR_LF  = 8'h0A;
  localparam logic [CharW-1:0] CLS_PAD  = 8'd64;
  localparam logic [CharW-1:0] CLS_BAD  = 8'd255;

  localparam logic [ErrW-1:0] ERR_NONE      = 2'd0;
  localparam logic [ErrW-1:0] ERR_ILLEGAL   = 2'd1;
  localparam logic [ErrW-1:0] ERR_PAD_POS   = 2'd2;
  localparam logic [ErrW-1:0] ERR_TRUNCATED = 2'd3;

  typedef struct packed {
    logic [CharW-1:0] data_byte;
    logic             byte_valid;
    logic             last_of_run;
    logic [ErrW-1:0]  error_code;
    logic             stream_done;
  } res_t;

  // 0..63 for an alphabet character, 64 for '=', 255 otherwise
  function automatic logic [CharW-1:0] classify(input logic [CharW-1:0] c);
    logic [CharW-1:0] v;
    v = CLS_BAD;
    if (c >= 8'd65 && c <= 8'd90) v = c - 8'd65;
    else if (c >= 8'd97 && c <= 8'd122) v = c - 8'd71;
    else if (c >= 8'd48 && c <= 8'd57) v = c + 8'd4;
    else if (c == 8'd43) v = 8'd62;
    else if (c == 8'd47) v = 8'd63;
    else if (c == 8'd61) v = CLS_PAD;
    return v;
  endfunction

endpackage

/* src/base64_stream_decoder.sv */
// top level of the base64 stream decoder: group state, decode and result queue
// results of an item are registered and offered in the cycle after it is accepted
// throughput: one input item per cycle while items give at most one result each and
//   out_tready stays high; a completed group gives up to three bytes, drained one per
//   cycle while out_tready is high, and the input waits until the last of them is taken
// reset: rst_n is synchronous and active low; it clears the group state, the error
//   latch and the result queue
module base64_stream_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [b64d_pkg::CharW-1:0]  in_tdata,   // in_char
  input  logic                        in_tlast,   // end_of_stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [b64d_pkg::CharW-1:0]  out_tdata,  // data_byte
  output logic                        out_tlast,  // last_of_run
  output logic [3:0]                  out_tuser   // byte_valid, error_code[1:0], stream_done
);
  import b64d_pkg::*;

  // group state
  logic [SextW-1:0] sx0_r, sx1_r, sx2_r;
  logic [SextW-1:0] sx0_nxt, sx1_nxt, sx2_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             s2pad_r, s2pad_nxt;
  logic             padseen_r, padseen_nxt;
  logic             errl_r, errl_nxt;

  // result queue, head at index 0
  res_t       q_r [QDepth];
  res_t       q_nxt [QDepth];
  logic [1:0] cnt_r, cnt_nxt;

  // results of the item being accepted
  res_t       new_q [QDepth];
  logic [1:0] new_cnt;

  logic             push, pop;
  logic [CharW-1:0] cls;
  logic             is_pad;
  logic [CharW-1:0] b0, b1, b2;
  logic [SextW-1:0] s3;

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  // room when the queue is empty or its last item leaves this cycle
  assign in_tready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign push       = in_tvalid && in_tready;

  assign out_tdata = q_r[0].data_byte;
  assign out_tlast = q_r[0].last_of_run;
  assign out_tuser = {q_r[0].stream_done, q_r[0].error_code, q_r[0].byte_valid};

  assign cls    = classify(in_tdata);
  assign is_pad = (cls == CLS_PAD);
  assign s3     = is_pad ? '0 : cls[SextW-1:0];

  // bytes of a completed group
  assign b0 = {sx0_r, sx1_r[5:4]};
  assign b1 = {sx1_r[3:0], sx2_r[5:2]};
  assign b2 = {sx2_r[1:0], s3};

  always_comb begin
    sx0_nxt     = sx0_r;
    sx1_nxt     = sx1_r;
    sx2_nxt     = sx2_r;
    fill_nxt    = fill_r;
    s2pad_nxt   = s2pad_r;
    padseen_nxt = padseen_r;
    errl_nxt    = errl_r;
    new_cnt     = 2'd0;
    for (int i = 0; i < QDepth; i++) begin
      new_q[i] = '0;
    end

    if (in_tlast) begin
      // end marker: report, then clear everything for the next stream
      new_q[0].last_of_run = 1'b1;
      new_q[0].stream_done = 1'b1;
      new_q[0].error_code  = (!errl_r && fill_r != 2'd0) ? ERR_TRUNCATED : ERR_NONE;
      new_cnt     = 2'd1;
      fill_nxt    = 2'd0;
      s2pad_nxt   = 1'b0;
      padseen_nxt = 1'b0;
      errl_nxt    = 1'b0;
    end else if (errl_r || in_tdata == CHAR_LF) begin
      // dropped silently
    end else if (cls == CLS_BAD || padseen_r ||
                 (fill_r[1] == 1'b0 && is_pad) ||
                 (fill_r == 2'd3 && s2pad_r && !is_pad)) begin
      new_q[0].last_of_run = 1'b1;
      new_q[0].error_code  = (cls == CLS_BAD) ? ERR_ILLEGAL : ERR_PAD_POS;
      new_cnt  = 2'd1;
      errl_nxt = 1'b1;
    end else begin
      case (fill_r)
        2'd0: begin
          sx0_nxt  = cls[SextW-1:0];
          fill_nxt = 2'd1;
        end
        2'd1: begin
          sx1_nxt  = cls[SextW-1:0];
          fill_nxt = 2'd2;
        end
        2'd2: begin
          s2pad_nxt = is_pad;
          sx2_nxt   = is_pad ? '0 : cls[SextW-1:0];
          fill_nxt  = 2'd3;
        end
        default: begin
          fill_nxt = 2'd0;
          new_q[0].data_byte  = b0;
          new_q[0].byte_valid = 1'b1;
          new_q[1].data_byte  = b1;
          new_q[1].byte_valid = 1'b1;
          new_q[2].data_byte  = b2;
          new_q[2].byte_valid = 1'b1;
          if (s2pad_r) begin
            // "==" closes the group with one byte
            s2pad_nxt   = 1'b0;
            padseen_nxt = 1'b1;
            new_q[0].last_of_run = 1'b1;
            new_cnt = 2'd1;
          end else if (is_pad) begin
            padseen_nxt = 1'b1;
            new_q[1].last_of_run = 1'b1;
            new_cnt = 2'd2;
          end else begin
            new_q[2].last_of_run = 1'b1;
            new_cnt = 2'd3;
          end
        end
      endcase
    end
  end

  // queue: load on accept (queue then empty or draining), else shift on pop
  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (push) begin
      q_nxt   = new_q;
      cnt_nxt = new_cnt;
    end else if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= 2'd0;
      s2pad_r   <= 1'b0;
      padseen_r <= 1'b0;
      errl_r    <= 1'b0;
      cnt_r     <= 2'd0;
    end else begin
      if (push) begin
        fill_r    <= fill_nxt;
        s2pad_r   <= s2pad_nxt;
        padseen_r <= padseen_nxt;
        errl_r    <= errl_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      sx0_r <= sx0_nxt;
      sx1_r <= sx1_nxt;
      sx2_r <= sx2_nxt;
    end
    q_r <= q_nxt;
  end

endmodule

/* bench/base64_stream_decoder_tb.sv */
// self-checking testbench for the base64 stream decoder: directed and random text streams
module base64_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  localparam int unsigned ItemTarget  = 230;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned SettleCycles = 10;

  // character codes used by the stimulus
  localparam logic [7:0] CH_EQ = 8'h3D;   // '=' padding

  // expected decode results, worked out from each accepted item
  class b64_result_tracker;
    localparam logic [6:0] VAL_PAD = 7'd64;
    localparam logic [6:0] VAL_BAD = 7'd127;

    logic [5:0] sextet_q [3];
    logic [1:0] slots_filled;
    logic       slot2_pad;
    logic       pad_done;
    logic       err_hold;
    res_t       expected_results[$];
    int         n_checked;
    int         n_fail;

    function new();
      clear_group();
      n_checked = 0;
      n_fail    = 0;
    endfunction

    function void clear_group();
      sextet_q     = '{default: '0};
      slots_filled = '0;
      slot2_pad    = 1'b0;
      pad_done     = 1'b0;
      err_hold     = 1'b0;
    endfunction

    // 0..63 for a sextet, VAL_PAD for '=', VAL_BAD for anything else
    function logic [6:0] char_value(logic [7:0] c);
      if (c >= "A" && c <= "Z") return 7'(c - "A");
      if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
      if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
      if (c == "+") return 7'd62;
      if (c == "/") return 7'd63;
      if (c == "=") return VAL_PAD;
      return VAL_BAD;
    endfunction

    function void push_result(logic [7:0] data, logic valid, logic last,
                              logic [ErrW-1:0] err, logic done);
      res_t r;
      r.data_byte   = data;
      r.byte_valid  = valid;
      r.last_of_run = last;
      r.error_code  = err;
      r.stream_done = done;
      expected_results.push_back(r);
    endfunction

    function void latch_error(logic [ErrW-1:0] err);
      err_hold = 1'b1;
      push_result(8'h00, 1'b0, 1'b1, err, 1'b0);
    endfunction

    // returns 1 when the item is skipped by the block
    function bit note_char(logic [7:0] c, logic eos);
      logic [6:0] v;
      logic [5:0] s3;
      logic [7:0] b0, b1, b2;
      if (eos) begin
        push_result(8'h00, 1'b0, 1'b1,
                    (!err_hold && slots_filled != 0) ? ERR_TRUNCATED : ERR_NONE, 1'b1);
        clear_group();
        return 1'b0;
      end
      if (err_hold || c == CHAR_LF) return 1'b1;
      v = char_value(c);
      if (v == VAL_BAD) begin
        latch_error(ERR_ILLEGAL);
        return 1'b0;
      end
      if (pad_done) begin
        latch_error(ERR_PAD_POS);
        return 1'b0;
      end
      if (slots_filled < 2) begin
        if (v == VAL_PAD) latch_error(ERR_PAD_POS);
        else begin
          sextet_q[slots_filled] = v[5:0];
          slots_filled = slots_filled + 1'b1;
        end
        return 1'b0;
      end
      if (slots_filled == 2) begin
        slot2_pad    = (v == VAL_PAD);
        sextet_q[2]  = (v == VAL_PAD) ? 6'd0 : v[5:0];
        slots_filled = 2'd3;
        return 1'b0;
      end
      // fourth slot closes the group
      if (slot2_pad && v != VAL_PAD) begin
        latch_error(ERR_PAD_POS);
        return 1'b0;
      end
      s3 = (v == VAL_PAD) ? 6'd0 : v[5:0];
      b0 = {sextet_q[0], sextet_q[1][5:4]};
      b1 = {sextet_q[1][3:0], sextet_q[2][5:2]};
      b2 = {sextet_q[2][1:0], s3};
      slots_filled = '0;
      if (slot2_pad) begin
        slot2_pad = 1'b0;
        pad_done  = 1'b1;
        push_result(b0, 1'b1, 1'b1, ERR_NONE, 1'b0);
      end else if (v == VAL_PAD) begin
        pad_done = 1'b1;
        push_result(b0, 1'b1, 1'b0, ERR_NONE, 1'b0);
        push_result(b1, 1'b1, 1'b1, ERR_NONE, 1'b0);
      end else begin
        push_result(b0, 1'b1, 1'b0, ERR_NONE, 1'b0);
        push_result(b1, 1'b1, 1'b0, ERR_NONE, 1'b0);
        push_result(b2, 1'b1, 1'b1, ERR_NONE, 1'b0);
      end
      return 1'b0;
    endfunction

    function void check_result(logic [7:0] data, logic last, logic [3:0] user);
      res_t e;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: tdata=%0h tlast=%0b tuser=%0h",
               data, last, user);
        n_fail++;
        return;
      end
      e = expected_results.pop_front();
      n_checked++;
      if (data !== e.data_byte) begin
        $error("data_byte: expected %0h, got %0h", e.data_byte, data);
        n_fail++;
      end
      if (user[0] !== e.byte_valid) begin
        $error("byte_valid: expected %0b, got %0b", e.byte_valid, user[0]);
        n_fail++;
      end
      if (last !== e.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", e.last_of_run, last);
        n_fail++;
      end
      if (user[2:1] !== e.error_code) begin
        $error("error_code: expected %0d, got %0d", e.error_code, user[2:1]);
        n_fail++;
      end
      if (user[3] !== e.stream_done) begin
        $error("stream_done: expected %0b, got %0b", e.stream_done, user[3]);
        n_fail++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;   // in_char
  logic       in_tlast   = 1'b0;    // end_of_stream
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;            // data_byte
  logic       out_tlast;            // last_of_run
  logic [3:0] out_tuser;            // byte_valid, error_code[1:0], stream_done

  b64_result_tracker tracker;

  // sender and receiver pacing
  bit in_no_idle  = 1'b0;
  bit out_no_idle = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_issued = 1'b0;
  int n_counted   = 0;
  int n_skipped   = 0;
  int n_streams   = 0;

  base64_stream_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // sextet index to alphabet character
  function automatic logic [7:0] alpha_char(int unsigned idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    if (idx == 62) return 8'("+");
    return 8'("/");
  endfunction

  // offer one item after a random gap, return at the edge where it is taken
  task automatic send_item(input logic [7:0] c, input logic eos);
    int gap;
    gap = in_no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    if (tracker.note_char(c, eos)) n_skipped++;
    n_counted++;
    // long output hold-off once, mid-run, with the sender still busy
    if (!hold_issued && n_counted >= 120) begin
      hold_req    = 1'b1;
      hold_issued = 1'b1;
    end
  endtask

  // a character, sometimes preceded by a line break
  task automatic send_char(input logic [7:0] c);
    if ($urandom_range(0, 7) == 0) send_item(CHAR_LF, 1'b0);
    send_item(c, 1'b0);
  endtask

  task automatic send_alpha();
    send_char(alpha_char($urandom_range(0, 63)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s.getc(i), 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
    n_streams++;
  endtask

  // one random stream: mostly well formed, some truncated, noisy or broken
  task automatic gen_stream();
    int kind;
    kind = $urandom_range(0, 9);
    in_no_idle = ($urandom_range(0, 3) == 0);
    if (kind != 7) repeat ($urandom_range(0, 4)) repeat (4) send_alpha();
    case (kind)
      6: begin
        // partial group left at the end marker
        repeat ($urandom_range(1, 3)) send_alpha();
      end
      7: begin
        repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
      end
      8, 9: begin
        case ($urandom_range(0, 4))
          0: send_char(CH_EQ);
          1: begin
            send_alpha();
            send_char(CH_EQ);
          end
          2: begin
            // lone padding in the third slot
            repeat (2) send_alpha();
            send_char(CH_EQ);
            send_alpha();
          end
          3: begin
            // anything after a padded group
            repeat (2) send_alpha();
            repeat (2) send_char(CH_EQ);
            if ($urandom_range(0, 1)) send_alpha();
            else send_char(CH_EQ);
          end
          default: begin
            if ($urandom_range(0, 1)) send_char(8'($urandom_range(128, 255)));
            else send_char(8'($urandom_range(0, 42)));
          end
        endcase
        // trailing junk is swallowed by the latched error, if one was latched
        repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(0, 255)));
      end
      default: begin
        case ($urandom_range(0, 2))
          1: begin
            repeat (3) send_alpha();
            send_char(CH_EQ);
          end
          2: begin
            repeat (2) send_alpha();
            repeat (2) send_char(CH_EQ);
          end
          default: ;
        endcase
      end
    endcase
    send_end();
  endtask

  // receiver: random stalls, bursts without stalls and one long hold-off
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 24) == 0) out_no_idle = !out_no_idle;
      if (hold_req) begin
        stall    = HoldCycles;
        hold_req = 1'b0;
      end else begin
        stall = out_no_idle ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_result(out_tdata, out_tlast, out_tuser);
    end
  end

  // main sequence
  initial begin
    int waited;
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a full group with a line break inside, alphabet edges, then an illegal byte
    send_text("/+\n9z");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);            // swallowed while the error is latched
    send_item(8'hFF, 1'b1);
    // double padding, then a character after the padded group
    send_text("TQ==B");
    send_end();
    // single padding, clean end
    send_text("AZa=");
    send_end();
    // padding in the first and second slot
    send_item(CH_EQ, 1'b0);
    send_item(8'h00, 1'b1);
    send_text("Q=");
    send_end();
    // lone padding in the third slot followed by data
    send_text("AA=B");
    send_end();
    // partial group at the end marker
    send_text("Qk");
    send_end();

    while (n_counted < ItemTarget) gen_stream();
    in_tvalid <= 1'b0;

    waited = 0;
    while (tracker.expected_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
    if (tracker.expected_results.size() != 0) begin
      $error("%0d expected results never arrived", tracker.expected_results.size());
      tracker.n_fail++;
    end

    $display("run covered %0d input items (%0d skipped) in %0d streams, checked %0d results",
             n_counted, n_skipped, n_streams, tracker.n_checked);
    $display("including padding, error, truncation cases and one long output hold-off");
    if (tracker.n_fail == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* base64_stream_decoder.f */
src/b64d_pkg.sv
src/base64_stream_decoder.sv
bench/base64_stream_decoder_tb.sv
